// File: sv/ucli_pkg.sv
// Shared types, constants and text tables of the UART command-line interpreter.
package ucli_pkg;

  localparam int LINE_BYTES_DEF = 64;
  localparam int SEND_BYTES_DEF = 64;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_LED     = 2'd1;
  localparam logic [1:0] KIND_ONESHOT = 2'd2;
  localparam logic [1:0] KIND_TIMER   = 2'd3;

  localparam int MSG_DONE_LEN = 31;
  localparam int MSG_INV_LEN  = 43;
  localparam int MSG_OVF_LEN  = 58;

  localparam logic [8*MSG_DONE_LEN-1:0] MSG_DONE = "Finished task. Send new prompt!";
  localparam logic [8*MSG_INV_LEN-1:0]  MSG_INV  =
    {"Invalid string entered. Please try again!", CHAR_CR, CHAR_LF};
  localparam logic [8*MSG_OVF_LEN-1:0]  MSG_OVF  =
    {"Message too long! Reset the ", 8'h53, 8'h54, 8'h4D, " and send a shorter string!"};

  // command prefixes, padded to eight bytes
  localparam logic [63:0] PAT_SERIAL  = {"serial ", 8'h00};
  localparam logic [63:0] PAT_LED     = {"led ", 32'h0};
  localparam logic [63:0] PAT_ONESHOT = "oneshot ";
  localparam logic [63:0] PAT_TIMER   = {"timer ", 16'h0};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TX,
    ST_RX,
    ST_CL_START,
    ST_CL_SCAN,
    ST_CL_DECIDE,
    ST_P_BIN,
    ST_P_SKIP,
    ST_P_SIGN,
    ST_P_DIG,
    ST_P_DONE,
    ST_CP_RUN,
    ST_CP_EMIT
  } state_e;

  typedef enum logic [2:0] {
    CLS_SERIAL,
    CLS_LED,
    CLS_ONESHOT,
    CLS_TIMER,
    CLS_INVALID
  } cls_e;

  typedef enum logic [1:0] {
    MSG_ECHO,
    MSG_FINISHED,
    MSG_INVALID,
    MSG_OVERFLOW
  } msg_e;

  typedef enum logic [1:0] {
    OUT_PEND,
    OUT_SEND,
    OUT_CR
  } out_src_e;

  typedef struct packed {
    logic     latch;
    logic     store;
    logic     cnt_clr;
    logic     idx_clr;
    logic     idx_inc;
    logic     idx_start;
    logic     scan_clr;
    logic     scan_en;
    logic     acc_clr;
    logic     acc_bin;
    logic     acc_dec;
    logic     neg_set;
    logic     pend_set;
    logic     pend_take;
    logic     spos_inc;
    logic     send_clr;
    logic     copy_start;
    logic     copy_step;
    logic     send_begin;
    logic     out_ld;
    msg_e     msg;
    out_src_e out_src;
  } cmd_t;

  typedef struct packed {
    logic is_cr;
    logic ovf_next;
    logic sending;
    logic pend_valid;
    logic tx_more;
    logic scan_last;
    cls_e cls;
    logic idx_end;
    logic ch_bin;
    logic ch_blank;
    logic ch_sign;
    logic ch_digit;
    logic copy_last;
  } sts_t;

  function automatic logic [5:0] msg_len(msg_e m);
    logic [5:0] n;
    n = 6'd0;
    unique case (m)
      MSG_FINISHED: n = 6'(MSG_DONE_LEN);
      MSG_INVALID:  n = 6'(MSG_INV_LEN);
      MSG_OVERFLOW: n = 6'(MSG_OVF_LEN);
      default:      n = 6'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] msg_byte(msg_e m, logic [5:0] i);
    logic [7:0] b;
    b = 8'h00;
    unique case (m)
      MSG_FINISHED: if (int'(i) < MSG_DONE_LEN) b = MSG_DONE[8*(MSG_DONE_LEN-1-int'(i)) +: 8];
      MSG_INVALID:  if (int'(i) < MSG_INV_LEN)  b = MSG_INV[8*(MSG_INV_LEN-1-int'(i)) +: 8];
      MSG_OVERFLOW: if (int'(i) < MSG_OVF_LEN)  b = MSG_OVF[8*(MSG_OVF_LEN-1-int'(i)) +: 8];
      default:      b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] pat_byte(logic [1:0] p, logic [2:0] i);
    logic [7:0] b;
    b = 8'h00;
    unique case (p)
      2'd0:    b = PAT_SERIAL[8*(7-int'(i)) +: 8];
      2'd1:    b = PAT_LED[8*(7-int'(i)) +: 8];
      2'd2:    b = PAT_ONESHOT[8*(7-int'(i)) +: 8];
      default: b = PAT_TIMER[8*(7-int'(i)) +: 8];
    endcase
    return b;
  endfunction

  function automatic logic [3:0] pat_len(logic [1:0] p);
    logic [3:0] n;
    n = 4'd0;
    unique case (p)
      2'd0:    n = 4'd7;
      2'd1:    n = 4'd4;
      2'd2:    n = 4'd8;
      default: n = 4'd6;
    endcase
    return n;
  endfunction

endpackage

// File: sv/ucli_dp.sv
// Datapath: line and reply memories, prefix scan, number parsing and output register.
module ucli_dp #(
  parameter int LINE_BYTES = ucli_pkg::LINE_BYTES_DEF,
  parameter int SEND_BYTES = ucli_pkg::SEND_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      rx_byte_i,
  input  ucli_pkg::cmd_t  cmd_i,
  output ucli_pkg::sts_t  sts_o,
  output logic [1:0]      kind_o,
  output logic [31:0]     value_o
);

  localparam int CW  = $clog2(LINE_BYTES);
  localparam int SAW = $clog2(SEND_BYTES);
  localparam int LW  = SAW + 1;
  localparam int MW  = (CW > LW) ? CW : LW;

  logic [7:0]  line_mem [LINE_BYTES];
  logic [7:0]  send_mem [SEND_BYTES];

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d, idx_begin;
  logic [7:0]    rdata_q, byte_q, sdata_q, cp_byte;
  logic [3:0]    match_q;
  logic [31:0]   acc_q;
  logic          neg_q;
  logic          pend_valid_q;
  logic [1:0]    pend_kind_q, act_kind;
  logic [31:0]   pend_value_q;
  logic [LW-1:0] k_q, n_q, len_q, spos_q, spos_d, echo_n, j;
  logic [MW-1:0] echo_raw;
  ucli_pkg::msg_e msg_q;
  logic          sending_q;
  logic [1:0]    kind_q;
  logic [31:0]   value_q;
  ucli_pkg::cls_e cls;

  always_comb begin
    priority if (match_q[0]) cls = ucli_pkg::CLS_SERIAL;
    else if (match_q[1])     cls = ucli_pkg::CLS_LED;
    else if (match_q[2])     cls = ucli_pkg::CLS_ONESHOT;
    else if (match_q[3])     cls = ucli_pkg::CLS_TIMER;
    else                     cls = ucli_pkg::CLS_INVALID;
  end

  always_comb begin
    unique case (cls)
      ucli_pkg::CLS_LED: begin
        idx_begin = CW'(ucli_pkg::pat_len(2'd1));
        act_kind  = ucli_pkg::KIND_LED;
      end
      ucli_pkg::CLS_ONESHOT: begin
        idx_begin = CW'(ucli_pkg::pat_len(2'd2));
        act_kind  = ucli_pkg::KIND_ONESHOT;
      end
      default: begin
        idx_begin = CW'(ucli_pkg::pat_len(2'd3));
        act_kind  = ucli_pkg::KIND_TIMER;
      end
    endcase
  end

  always_comb begin
    priority if (cmd_i.idx_clr)             idx_d = '0;
    else if (cmd_i.idx_start)               idx_d = idx_begin;
    else if (cmd_i.copy_start)              idx_d = CW'(5);
    else if (cmd_i.idx_inc || cmd_i.copy_step) idx_d = idx_q + CW'(1);
    else                                    idx_d = idx_q;
  end

  always_comb begin
    priority if (cmd_i.cnt_clr || cmd_i.copy_start) cnt_d = '0;
    else if (cmd_i.store)                          cnt_d = cnt_q + CW'(1);
    else                                           cnt_d = cnt_q;
  end

  always_comb begin
    priority if (cmd_i.send_clr) spos_d = '0;
    else if (cmd_i.send_begin)   spos_d = LW'(1);
    else if (cmd_i.spos_inc)     spos_d = spos_q + LW'(1);
    else                         spos_d = spos_q;
  end

  // echo text runs from the eighth stored byte, cut to what the reply holds
  assign echo_raw = MW'(cnt_q) - MW'(7);
  assign echo_n   = (echo_raw > MW'(SEND_BYTES - 4)) ? LW'(SEND_BYTES - 4) : LW'(echo_raw);

  assign j = k_q - LW'(2);
  always_comb begin
    priority if (k_q == '0)        cp_byte = ucli_pkg::CHAR_CR;
    else if (k_q == LW'(1))        cp_byte = ucli_pkg::CHAR_LF;
    else if (k_q == n_q + LW'(2))  cp_byte = ucli_pkg::CHAR_CR;
    else if (k_q == n_q + LW'(3))  cp_byte = ucli_pkg::CHAR_LF;
    else if (msg_q == ucli_pkg::MSG_ECHO) cp_byte = rdata_q;
    else                           cp_byte = ucli_pkg::msg_byte(msg_q, j[5:0]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      line_mem[cnt_q] <= byte_q;
    end
    rdata_q <= line_mem[idx_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.copy_step) begin
      send_mem[k_q[SAW-1:0]] <= cp_byte;
    end
    sdata_q <= send_mem[spos_d[SAW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      spos_q       <= '0;
      len_q        <= '0;
      sending_q    <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      spos_q <= spos_d;
      if (cmd_i.send_clr) begin
        len_q     <= '0;
        sending_q <= 1'b0;
      end else if (cmd_i.send_begin) begin
        len_q     <= n_q + LW'(4);
        sending_q <= 1'b1;
      end
      if (cmd_i.pend_set) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.pend_take) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.latch) begin
      byte_q <= rx_byte_i;
    end
    if (cmd_i.scan_clr) begin
      match_q <= '1;
    end else if (cmd_i.scan_en) begin
      for (int p = 0; p < 4; p++) begin
        if (!(idx_q >= CW'(ucli_pkg::pat_len(2'(p))) ||
              (idx_q < cnt_q && rdata_q == ucli_pkg::pat_byte(2'(p), idx_q[2:0])))) begin
          match_q[p] <= 1'b0;
        end
      end
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
      neg_q <= 1'b0;
    end else begin
      if (cmd_i.acc_bin) begin
        acc_q <= {acc_q[30:0], rdata_q[0]};
      end else if (cmd_i.acc_dec) begin
        acc_q <= (acc_q << 3) + (acc_q << 1) + 32'(rdata_q[3:0]);
      end
      if (cmd_i.neg_set && rdata_q == 8'h2D) begin
        neg_q <= 1'b1;
      end
    end
    if (cmd_i.pend_set) begin
      pend_kind_q  <= act_kind;
      pend_value_q <= neg_q ? (32'd0 - acc_q) : acc_q;
    end
    if (cmd_i.copy_start) begin
      k_q   <= '0;
      msg_q <= cmd_i.msg;
      n_q   <= (cmd_i.msg == ucli_pkg::MSG_ECHO) ? echo_n : LW'(ucli_pkg::msg_len(cmd_i.msg));
    end else if (cmd_i.copy_step) begin
      k_q <= k_q + LW'(1);
    end
    if (cmd_i.out_ld) begin
      unique case (cmd_i.out_src)
        ucli_pkg::OUT_PEND: begin
          kind_q  <= pend_kind_q;
          value_q <= pend_value_q;
        end
        ucli_pkg::OUT_SEND: begin
          kind_q  <= ucli_pkg::KIND_TX;
          value_q <= 32'(sdata_q);
        end
        default: begin
          kind_q  <= ucli_pkg::KIND_TX;
          value_q <= 32'(ucli_pkg::CHAR_CR);
        end
      endcase
    end
  end

  assign kind_o  = kind_q;
  assign value_o = value_q;

  always_comb begin
    sts_o.is_cr      = (byte_q == ucli_pkg::CHAR_CR);
    sts_o.ovf_next   = (cnt_q == CW'(LINE_BYTES - 3));
    sts_o.sending    = sending_q;
    sts_o.pend_valid = pend_valid_q;
    sts_o.tx_more    = (spos_q < len_q);
    sts_o.scan_last  = (idx_q == CW'(7));
    sts_o.cls        = cls;
    sts_o.idx_end    = (idx_q >= cnt_q);
    sts_o.ch_bin     = (rdata_q == 8'h30) || (rdata_q == 8'h31);
    sts_o.ch_blank   = (rdata_q == 8'h20) || (rdata_q >= 8'h09 && rdata_q <= 8'h0D);
    sts_o.ch_sign    = (rdata_q == 8'h2B) || (rdata_q == 8'h2D);
    sts_o.ch_digit   = (rdata_q >= 8'h30) && (rdata_q <= 8'h39);
    sts_o.copy_last  = (k_q == n_q + LW'(3));
  end

  a_spos_in_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spos_q <= len_q)
    else $error("reply position beyond reply length");

  a_reply_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sending_q) |-> (spos_q == LW'(1) && len_q >= LW'(4)))
    else $error("reply started without framing");

  a_line_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(LINE_BYTES - 2))
    else $error("line count past its limit");

endmodule

// File: sv/ucli_ctrl.sv
// Controller: sequencer for request handling, line classification, parsing and reply set-up.
module ucli_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           func_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  ucli_pkg::sts_t sts_i,
  output ucli_pkg::cmd_t cmd_o
);

  ucli_pkg::state_e state_q, state_d;
  logic out_valid_q, out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ucli_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ucli_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.msg     = ucli_pkg::MSG_ECHO;
    cmd_o.out_src = ucli_pkg::OUT_CR;
    unique case (state_q)
      ucli_pkg::ST_IDLE: begin
        cmd_o.latch = in_valid_i;
        if (in_valid_i) begin
          state_d = func_i ? ucli_pkg::ST_TX : ucli_pkg::ST_RX;
        end
      end
      ucli_pkg::ST_TX: begin
        priority if (sts_i.pend_valid) begin
          if (out_free) begin
            cmd_o.out_ld    = 1'b1;
            cmd_o.out_src   = ucli_pkg::OUT_PEND;
            cmd_o.pend_take = 1'b1;
            state_d         = ucli_pkg::ST_IDLE;
          end
        end else if (sts_i.tx_more) begin
          if (out_free) begin
            cmd_o.out_ld   = 1'b1;
            cmd_o.out_src  = ucli_pkg::OUT_SEND;
            cmd_o.spos_inc = 1'b1;
            state_d        = ucli_pkg::ST_IDLE;
          end
        end else begin
          cmd_o.send_clr = 1'b1;
          state_d        = ucli_pkg::ST_IDLE;
        end
      end
      ucli_pkg::ST_RX: begin
        cmd_o.store = 1'b1;
        priority if (sts_i.is_cr) begin
          if (sts_i.sending) begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = ucli_pkg::ST_IDLE;
          end else begin
            state_d = ucli_pkg::ST_CL_START;
          end
        end else if (sts_i.ovf_next) begin
          cmd_o.cnt_clr = 1'b1;
          if (!sts_i.sending) begin
            cmd_o.copy_start = 1'b1;
            cmd_o.msg        = ucli_pkg::MSG_OVERFLOW;
            state_d          = ucli_pkg::ST_CP_RUN;
          end else begin
            state_d = ucli_pkg::ST_IDLE;
          end
        end else begin
          state_d = ucli_pkg::ST_IDLE;
        end
      end
      ucli_pkg::ST_CL_START: begin
        cmd_o.idx_clr  = 1'b1;
        cmd_o.scan_clr = 1'b1;
        state_d        = ucli_pkg::ST_CL_SCAN;
      end
      ucli_pkg::ST_CL_SCAN: begin
        cmd_o.scan_en = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ucli_pkg::ST_CL_DECIDE;
        end
      end
      ucli_pkg::ST_CL_DECIDE: begin
        cmd_o.acc_clr = 1'b1;
        unique case (sts_i.cls)
          ucli_pkg::CLS_SERIAL: begin
            cmd_o.copy_start = 1'b1;
            cmd_o.msg        = ucli_pkg::MSG_ECHO;
            state_d          = ucli_pkg::ST_CP_RUN;
          end
          ucli_pkg::CLS_LED: begin
            cmd_o.idx_start = 1'b1;
            state_d         = ucli_pkg::ST_P_BIN;
          end
          ucli_pkg::CLS_ONESHOT, ucli_pkg::CLS_TIMER: begin
            cmd_o.idx_start = 1'b1;
            state_d         = ucli_pkg::ST_P_SKIP;
          end
          default: begin
            cmd_o.copy_start = 1'b1;
            cmd_o.msg        = ucli_pkg::MSG_INVALID;
            state_d          = ucli_pkg::ST_CP_RUN;
          end
        endcase
      end
      ucli_pkg::ST_P_BIN: begin
        if (!sts_i.idx_end && sts_i.ch_bin) begin
          cmd_o.acc_bin = 1'b1;
          cmd_o.idx_inc = 1'b1;
        end else begin
          state_d = ucli_pkg::ST_P_DONE;
        end
      end
      ucli_pkg::ST_P_SKIP: begin
        if (!sts_i.idx_end && sts_i.ch_blank) begin
          cmd_o.idx_inc = 1'b1;
        end else begin
          state_d = ucli_pkg::ST_P_SIGN;
        end
      end
      ucli_pkg::ST_P_SIGN: begin
        if (!sts_i.idx_end && sts_i.ch_sign) begin
          cmd_o.neg_set = 1'b1;
          cmd_o.idx_inc = 1'b1;
        end
        state_d = ucli_pkg::ST_P_DIG;
      end
      ucli_pkg::ST_P_DIG: begin
        if (!sts_i.idx_end && sts_i.ch_digit) begin
          cmd_o.acc_dec = 1'b1;
          cmd_o.idx_inc = 1'b1;
        end else begin
          state_d = ucli_pkg::ST_P_DONE;
        end
      end
      ucli_pkg::ST_P_DONE: begin
        cmd_o.pend_set   = 1'b1;
        cmd_o.copy_start = 1'b1;
        cmd_o.msg        = ucli_pkg::MSG_FINISHED;
        state_d          = ucli_pkg::ST_CP_RUN;
      end
      ucli_pkg::ST_CP_RUN: begin
        cmd_o.copy_step = 1'b1;
        if (sts_i.copy_last) begin
          state_d = ucli_pkg::ST_CP_EMIT;
        end
      end
      ucli_pkg::ST_CP_EMIT: begin
        // the opening CR of the reply leaves with the line end
        if (out_free) begin
          cmd_o.out_ld     = 1'b1;
          cmd_o.out_src    = ucli_pkg::OUT_CR;
          cmd_o.send_begin = 1'b1;
          state_d          = ucli_pkg::ST_IDLE;
        end
      end
      default: state_d = ucli_pkg::ST_IDLE;
    endcase
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.out_ld && out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  a_rx_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !func_i) |=> state_q == ucli_pkg::ST_RX)
    else $error("received byte not stored");

  a_tx_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && func_i) |=> state_q == ucli_pkg::ST_TX)
    else $error("ready request not served");

endmodule

// File: sv/uart_command_line_interpreter.sv
// Top level of the UART command-line interpreter.
//
//   channel | signals                          | direction
//   in      | in_valid_i, in_stall_o, func_i, rx_byte_i | request in
//   out     | out_valid_o, out_stall_i, kind_o, value_o | result out
//
// Transmitter-ready requests and received bytes are served one at a time. A line end is
// classified, its number parsed character by character and its reply copied byte by byte
// (up to SEND_BYTES), all in the controller's sequencer over one line-memory read port.
// Reset clears line count, reply position and length, flags and sequencer, not the memories.
// in_stall_o is high while a request is being worked on; a stalled result holds
// the sequencer only when it has a new result to hand over.
module uart_command_line_interpreter #(
  parameter int LINE_BYTES = ucli_pkg::LINE_BYTES_DEF,
  parameter int SEND_BYTES = ucli_pkg::SEND_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] value_o
);

  ucli_pkg::cmd_t cmd;
  ucli_pkg::sts_t sts;

  ucli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ucli_dp #(
    .LINE_BYTES (LINE_BYTES),
    .SEND_BYTES (SEND_BYTES)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_byte_i (rx_byte_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .kind_o    (kind_o),
    .value_o   (value_o)
  );

endmodule

// File: verif/uart_command_line_interpreter_test.sv
// Testbench for the UART command-line interpreter: line stimulus, predictor and result checker.
`timescale 1ns / 1ps

module uart_command_line_interpreter_test;

  localparam int LINE_MAX  = ucli_pkg::LINE_BYTES_DEF - 2;
  localparam int ECHO_MAX  = ucli_pkg::SEND_BYTES_DEF - 4;
  localparam int CYCLE_CAP = 1_000_000;
  localparam int RAND_REQS = 280;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = 1'b0;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [31:0] value_o;

  // shadow state of the interpreter
  logic [7:0]  line_mem [ucli_pkg::LINE_BYTES_DEF];
  int          line_cnt;
  logic [7:0]  reply_mem [ucli_pkg::SEND_BYTES_DEF];
  int          reply_len;
  int          reply_pos;
  bit          tx_busy;
  bit          action_waiting;
  result_t     action_held;

  result_t     due_results [$];
  int          errors;
  int          cycles;
  int          req_count;
  int          gap_pct;
  int          stall_pct;

  uart_command_line_interpreter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .kind_o     (kind_o),
    .value_o    (value_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $display("%0t: result expected none actual kind %0d value %h", $time, kind_o, value_o);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (kind_o !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind_o);
          errors++;
        end
        if (value_o !== want.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value, value_o);
          errors++;
        end
      end
    end
  end

  task automatic frame_reply(input logic [7:0] txt [$], output bit started);
    int n;
    started = 1'b0;
    if (tx_busy) return;
    n = (txt.size() > ECHO_MAX) ? ECHO_MAX : txt.size();
    reply_mem[0] = ucli_pkg::CHAR_CR;
    reply_mem[1] = ucli_pkg::CHAR_LF;
    for (int i = 0; i < n; i++) reply_mem[i + 2] = txt[i];
    reply_mem[n + 2] = ucli_pkg::CHAR_CR;
    reply_mem[n + 3] = ucli_pkg::CHAR_LF;
    reply_len = n + 4;
    reply_pos = 1;
    tx_busy = 1'b1;
    due_results.push_back('{ucli_pkg::KIND_TX, 32'(ucli_pkg::CHAR_CR)});
    started = 1'b1;
  endtask

  function automatic bit line_has_prefix(string p);
    if (line_cnt < p.len()) return 1'b0;
    for (int i = 0; i < p.len(); i++)
      if (line_mem[i] != p[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [31:0] read_binary(int pos);
    logic [31:0] v;
    v = '0;
    while (pos < line_cnt && (line_mem[pos] == "0" || line_mem[pos] == "1")) begin
      v = {v[30:0], line_mem[pos][0]};
      pos++;
    end
    return v;
  endfunction

  function automatic logic [31:0] read_decimal(int pos);
    logic [31:0] v;
    bit neg;
    v = '0;
    neg = 1'b0;
    while (pos < line_cnt && (line_mem[pos] == " " ||
           (line_mem[pos] >= 8'd9 && line_mem[pos] <= 8'd13)))
      pos++;
    if (pos < line_cnt && (line_mem[pos] == "+" || line_mem[pos] == "-")) begin
      neg = line_mem[pos] == "-";
      pos++;
    end
    while (pos < line_cnt && line_mem[pos] >= "0" && line_mem[pos] <= "9") begin
      v = v * 32'd10 + 32'(line_mem[pos] - "0");
      pos++;
    end
    return neg ? -v : v;
  endfunction

  task automatic classify_line();
    logic [7:0] txt [$];
    result_t act;
    bit started;
    if (line_has_prefix("serial ")) begin
      for (int i = 7; i < line_cnt; i++) txt.push_back(line_mem[i]);
      frame_reply(txt, started);
      return;
    end
    if (line_has_prefix("led ")) act = '{ucli_pkg::KIND_LED, read_binary(4)};
    else if (line_has_prefix("oneshot ")) act = '{ucli_pkg::KIND_ONESHOT, read_decimal(8)};
    else if (line_has_prefix("timer ")) act = '{ucli_pkg::KIND_TIMER, read_decimal(6)};
    else begin
      for (int i = 0; i < ucli_pkg::MSG_INV_LEN; i++)
        txt.push_back(ucli_pkg::MSG_INV[8*(ucli_pkg::MSG_INV_LEN-1-i) +: 8]);
      frame_reply(txt, started);
      return;
    end
    for (int i = 0; i < ucli_pkg::MSG_DONE_LEN; i++)
      txt.push_back(ucli_pkg::MSG_DONE[8*(ucli_pkg::MSG_DONE_LEN-1-i) +: 8]);
    frame_reply(txt, started);
    if (started) begin
      action_waiting = 1'b1;
      action_held = act;
    end
  endtask

  task automatic interpret_event(input bit f, input logic [7:0] b);
    logic [7:0] txt [$];
    bit started;
    if (f) begin
      if (action_waiting) begin
        action_waiting = 1'b0;
        due_results.push_back(action_held);
      end else if (reply_pos < reply_len) begin
        due_results.push_back('{ucli_pkg::KIND_TX, 32'(reply_mem[reply_pos])});
        reply_pos++;
      end else begin
        reply_pos = 0;
        reply_len = 0;
        tx_busy = 1'b0;
      end
      return;
    end
    if (line_cnt < LINE_MAX) begin
      line_mem[line_cnt] = b;
      line_cnt++;
    end
    if (b == ucli_pkg::CHAR_CR) begin
      if (!tx_busy) classify_line();
      line_cnt = 0;
    end
    if (line_cnt >= LINE_MAX) begin
      for (int i = 0; i < ucli_pkg::MSG_OVF_LEN; i++)
        txt.push_back(ucli_pkg::MSG_OVF[8*(ucli_pkg::MSG_OVF_LEN-1-i) +: 8]);
      frame_reply(txt, started);
      line_cnt = 0;
    end
  endtask

  // valid stays high between back-to-back requests; it drops only for a gap
  task automatic send_request(input bit f, input logic [7:0] b);
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    rx_byte_i <= b;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    interpret_event(f, b);
    req_count++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_request(1'b0, s[i]);
  endtask

  task automatic drain_reply();
    while (tx_busy) send_request(1'b1, 8'h00);
  endtask

  task automatic test_directed();
    send_request(1'b1, 8'hFF);          // ready while idle
    send_text("led 10110\r");
    send_request(1'b0, ucli_pkg::CHAR_CR);  // line end while busy: dropped
    drain_reply();
    send_text("oneshot \t -4294967297x\r");
    drain_reply();
    send_text("timer +99\r");
    drain_reply();
    send_text("serial ");
    send_request(1'b0, 8'hFF);
    send_request(1'b0, 8'h00);
    send_request(1'b0, ucli_pkg::CHAR_CR);
    drain_reply();
    send_text("bogus\r");
    drain_reply();
  endtask

  task automatic test_overflow();
    for (int i = 0; i < LINE_MAX; i++) send_request(1'b0, "a");
    for (int i = 0; i < LINE_MAX; i++) send_request(1'b0, "b");  // overflow while busy
    drain_reply();
    send_text("serial ");
    for (int i = 0; i < LINE_MAX - 8; i++) send_request(1'b0, 8'($urandom_range(255, 14)));
    send_request(1'b0, ucli_pkg::CHAR_CR);  // stored in the last free slot
    drain_reply();
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    return (c == ucli_pkg::CHAR_CR) ? 8'h0E : c;
  endfunction

  task automatic send_random_line();
    string blanks;
    int pick;
    blanks = " \t\n\v\f";
    pick = $urandom_range(9);
    case (pick)
      0, 1: begin
        send_text("serial ");
        repeat ($urandom_range(LINE_MAX - 8)) send_request(1'b0, plain_byte());
      end
      2, 3: begin
        send_text("led ");
        repeat ($urandom_range(40)) send_request(1'b0, $urandom_range(1) ? "1" : "0");
      end
      4, 5, 6: begin
        send_text($urandom_range(1) ? "oneshot " : "timer ");
        repeat ($urandom_range(2)) send_request(1'b0, blanks[$urandom_range(4)]);
        case ($urandom_range(2))
          0: send_request(1'b0, "-");
          1: send_request(1'b0, "+");
          default: ;
        endcase
        repeat ($urandom_range(12)) send_request(1'b0, 8'("0" + $urandom_range(9)));
      end
      7: repeat ($urandom_range(10)) send_request(1'b0, plain_byte());
      8: repeat ($urandom_range(LINE_MAX + 10, LINE_MAX)) send_request(1'b0, plain_byte());
      default: ;
    endcase
    if ($urandom_range(3) == 0) send_request(1'b0, plain_byte());
    send_request(1'b0, ucli_pkg::CHAR_CR);
  endtask

  task automatic test_random();
    int start;
    start = req_count;
    while (req_count - start < RAND_REQS) begin
      case (((req_count - start) * 4 / RAND_REQS) % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 65; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 65; end
        default: begin gap_pct = 13; stall_pct = 13; end
      endcase
      send_random_line();
      // sometimes type into a busy transmitter, then let the reply run out
      while (tx_busy) begin
        if ($urandom_range(9) == 0) send_request(1'b0, ($urandom_range(3) == 0) ?
                                                 ucli_pkg::CHAR_CR : plain_byte());
        else send_request(1'b1, 8'($urandom_range(255)));
      end
      if ($urandom_range(7) == 0) send_request(1'b1, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    line_cnt = 0;
    reply_len = 0;
    reply_pos = 0;
    tx_busy = 1'b0;
    action_waiting = 1'b0;
    errors = 0;
    cycles = 0;
    req_count = 0;
    gap_pct = 0;
    stall_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_random();
    in_valid_i <= 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && due_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
sv/ucli_pkg.sv
sv/ucli_dp.sv
sv/ucli_ctrl.sv
sv/uart_command_line_interpreter.sv
verif/uart_command_line_interpreter_test.sv
